// ===== src/assert_macros.svh =====
// assertion macros shared by the quintic offset decay rtl
// depends on nothing; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define QODE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define QODE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define QODE_ASSERT(lbl, clk, rst_n, prop)
`define QODE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/qode_pkg.sv =====
// constants and side-band types for the quintic offset decay evaluator
// depends on nothing
package qode_pkg;

    localparam int FRAC_BITS = 16;
    localparam int UBITS     = 30;
    localparam int LIM_BITS  = 32;
    localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;
    localparam logic [30:0] ONE_U   = 31'h4000_0000;

    typedef struct packed {
        logic [30:0] x0;
        logic        vneg;
        logic        shorten;
        logic [31:0] t1;
        logic [31:0] t;
        logic        zero;
    } t_side1;

    typedef struct packed {
        logic [30:0] x0;
        logic        vneg;
        logic [31:0] vm;
        logic        zero;
    } t_side2;

endpackage

// ===== src/qode_div_cell.sv =====
// one restoring divide cell: one quotient bit per beat, registered
// depends on assert_macros.svh
`include "assert_macros.svh"

module qode_div_cell #(
    parameter int RW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_sh,
    input  logic [RW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [RW-1:0] o_rem,
    output logic [QW-1:0] o_sh,
    output logic [RW-1:0] o_div,
    output logic [SW-1:0] o_side
);

    logic          r_valid;
    logic [RW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_sh, n_sh;
    logic [RW-1:0] r_div;
    logic [SW-1:0] r_side;
    logic [RW:0]   w_trial, w_diff;
    logic          w_ge;

    always_comb begin
        w_trial = {i_rem, i_sh[QW-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = w_trial >= {1'b0, i_div};
        n_rem   = w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
        n_sh    = {i_sh[QW-2:0], w_ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem  <= n_rem;
            r_sh   <= n_sh;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_sh    = r_sh;
    assign o_div   = r_div;
    assign o_side  = r_side;

    // partial remainder stays below the divisor
    `QODE_ASSERT_NEVER(a_rem_below_div, i_clk, i_rst_n, r_valid && r_div != '0 && r_rem >= r_div)

endmodule

// ===== src/qode_poly.sv =====
// multiply pipeline for the quintic decay polynomial, clamp and saturation
// depends on qode_pkg and assert_macros.svh
`include "assert_macros.svh"

module qode_poly #(
    parameter int FRAC_BITS = qode_pkg::FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [29:0]          i_u,
    input  logic [31:0]          i_t1,
    input  qode_pkg::t_side2     i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [30:0]          o_offset_now
);

    logic             r_v [1:7];
    logic             w_rdy [1:8];
    qode_pkg::t_side2 r_sd [1:6];
    logic [31:0]      r_t1 [1:5];

    logic [29:0] r_u1, r_uu1, r_u2;
    logic [30:0] r_w1, r_ww1, r_w3, r_h3, r_uw3, r_g4, r_a4, r_a5, r_a6;
    logic [33:0] r_p2;
    logic [31:0] r_q2, r_q3, r_vg5;
    logic [63:0] r_b6;
    logic [30:0] r_out, n_out;
    logic [30:0] w_w;
    logic [63:0] w_sum;

    always_comb begin
        w_rdy[8] = i_ready;
        for (int k = 7; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 7; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (w_rdy[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= 7; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign w_w = qode_pkg::ONE_U - 31'(i_u);

    always_comb begin
        w_sum = 64'(r_a6) + r_b6;
        if (r_sd[6].zero) begin
            n_out = '0;
        end else if (r_sd[6].vneg) begin
            n_out = (r_b6 >= 64'(r_a6)) ? '0 : (r_a6 - r_b6[30:0]);
        end else if (w_sum > 64'(qode_pkg::OUT_MAX)) begin
            n_out = qode_pkg::OUT_MAX;
        end else begin
            n_out = w_sum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_sd[1] <= i_side;
            r_t1[1] <= i_t1;
            r_u1    <= i_u;
            r_w1    <= w_w;
            r_uu1   <= 30'((60'(i_u) * 60'(i_u)) >> qode_pkg::UBITS);
            r_ww1   <= 31'((62'(w_w) * 62'(w_w)) >> qode_pkg::UBITS);
        end
        if (w_rdy[2]) begin
            r_sd[2] <= r_sd[1];
            r_t1[2] <= r_t1[1];
            r_u2    <= r_u1;
            r_w3    <= 31'((62'(r_ww1) * 62'(r_w1)) >> qode_pkg::UBITS);
            r_p2    <= 34'(qode_pkg::ONE_U) + 34'(r_u1) * 34'd3 + 34'(r_uu1) * 34'd6;
            r_q2    <= 32'(qode_pkg::ONE_U) + 32'(r_u1) * 32'd3;
        end
        if (w_rdy[3]) begin
            r_sd[3] <= r_sd[2];
            r_t1[3] <= r_t1[2];
            r_h3    <= 31'((65'(r_w3) * 65'(r_p2)) >> qode_pkg::UBITS);
            r_uw3   <= 31'((61'(r_u2) * 61'(r_w3)) >> qode_pkg::UBITS);
            r_q3    <= r_q2;
        end
        if (w_rdy[4]) begin
            r_sd[4] <= r_sd[3];
            r_t1[4] <= r_t1[3];
            r_g4    <= 31'((63'(r_uw3) * 63'(r_q3)) >> qode_pkg::UBITS);
            r_a4    <= 31'((62'(r_sd[3].x0) * 62'(r_h3)) >> qode_pkg::UBITS);
        end
        if (w_rdy[5]) begin
            r_sd[5] <= r_sd[4];
            r_t1[5] <= r_t1[4];
            r_vg5   <= 32'((63'(r_sd[4].vm) * 63'(r_g4)) >> qode_pkg::UBITS);
            r_a5    <= r_a4;
        end
        if (w_rdy[6]) begin
            r_sd[6] <= r_sd[5];
            r_b6    <= (64'(r_vg5) * 64'(r_t1[5])) >> FRAC_BITS;
            r_a6    <= r_a5;
        end
        if (w_rdy[7]) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_v[7];
    assign o_offset_now = r_out;

    // cube of one minus u never exceeds one
    `QODE_ASSERT_NEVER(a_w3_range, i_clk, i_rst_n, r_v[2] && r_w3 > qode_pkg::ONE_U)
    // basis values stay within one
    `QODE_ASSERT_NEVER(a_h_range, i_clk, i_rst_n, r_v[3] && r_h3 > qode_pkg::ONE_U)
    `QODE_ASSERT_NEVER(a_g_range, i_clk, i_rst_n, r_v[3] && r_uw3 > qode_pkg::ONE_U)
    // a stalled stage keeps its beat
    `QODE_ASSERT(a_stage_hold, i_clk, i_rst_n, r_v[6] && !w_rdy[7] |=> r_v[6] && $stable(r_a6) && $stable(r_b6))

endmodule

// ===== src/quintic_offset_decay_eval.sv =====
// Inertialization offset decay: one unsigned Q15.16 result per input beat, one beat accepted
// per cycle unless the output stalls. Beats pass 32 cells of the duration-limit divider, 30
// cells of the normalized-time divider and 7 multiply stages. Every stage has its own valid
// and ready, so a stalled output only holds the beats that are queued behind it.
// depends on qode_pkg, qode_div_cell, qode_poly

module quintic_offset_decay_eval #(
    parameter int FRAC_BITS = qode_pkg::FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_offset_start,
    input  logic [31:0] i_velocity_start,
    input  logic [31:0] i_blend_duration,
    input  logic [31:0] i_elapsed_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [30:0] o_offset_now
);

    localparam int NW  = 34 + FRAC_BITS;
    localparam int HW  = NW - qode_pkg::LIM_BITS;
    localparam int CW  = (HW > 32) ? HW : 32;
    localparam int S1W = $bits(qode_pkg::t_side1);
    localparam int S2W = $bits(qode_pkg::t_side2);
    localparam int N1  = qode_pkg::LIM_BITS;
    localparam int N2  = qode_pkg::UBITS;

    logic          d1_v   [0:N1];
    logic          d1_r   [0:N1];
    logic [31:0]   d1_rem [0:N1];
    logic [31:0]   d1_sh  [0:N1];
    logic [31:0]   d1_div [0:N1];
    logic [S1W-1:0] d1_sd [0:N1];

    logic          d2_v   [0:N2];
    logic          d2_r   [0:N2];
    logic [31:0]   d2_rem [0:N2];
    logic [29:0]   d2_sh  [0:N2];
    logic [31:0]   d2_div [0:N2];
    logic [S2W-1:0] d2_sd [0:N2];

    logic [31:0]       w_vm;
    logic [33:0]       w_x5;
    logic [NW-1:0]     w_num;
    logic [HW-1:0]     w_hi;
    logic              w_xpos, w_vneg, w_big;
    qode_pkg::t_side1  w_s1, w_s1o;
    qode_pkg::t_side2  w_s2, w_s2o;
    logic [31:0]       w_lim, w_t1e;

    always_comb begin
        w_vneg = i_velocity_start[31];
        w_vm   = w_vneg ? (32'd0 - i_velocity_start) : i_velocity_start;
        w_xpos = !i_offset_start[31] && (i_offset_start != '0);
        w_x5   = {1'b0, i_offset_start[30:0], 2'b00} + 34'(i_offset_start[30:0]);
        w_num  = {w_x5, {FRAC_BITS{1'b0}}};
        w_hi   = w_num[NW-1:qode_pkg::LIM_BITS];
        w_big  = CW'(w_hi) >= CW'(w_vm);

        w_s1.x0      = i_offset_start[30:0];
        w_s1.vneg    = w_vneg;
        w_s1.shorten = w_vneg && !w_big;
        w_s1.t1      = i_blend_duration;
        w_s1.t       = i_elapsed_time;
        w_s1.zero    = (i_blend_duration == '0) || !w_xpos;

        d1_v[0]   = i_valid;
        d1_rem[0] = w_s1.shorten ? 32'(w_hi) : '0;
        d1_sh[0]  = w_num[31:0];
        d1_div[0] = w_vm;
        d1_sd[0]  = w_s1;
    end

    assign o_ready = d1_r[0];

    for (genvar k = 0; k < N1; k++) begin : g_lim
        qode_div_cell #(.RW(32), .QW(N1), .SW(S1W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d1_v[k]),
            .o_ready (d1_r[k]),
            .i_rem   (d1_rem[k]),
            .i_sh    (d1_sh[k]),
            .i_div   (d1_div[k]),
            .i_side  (d1_sd[k]),
            .o_valid (d1_v[k+1]),
            .i_ready (d1_r[k+1]),
            .o_rem   (d1_rem[k+1]),
            .o_sh    (d1_sh[k+1]),
            .o_div   (d1_div[k+1]),
            .o_side  (d1_sd[k+1])
        );
    end

    // shortened duration and early-out checks
    always_comb begin
        w_s1o = qode_pkg::t_side1'(d1_sd[N1]);
        w_lim = d1_sh[N1];
        w_t1e = (w_s1o.shorten && w_lim < w_s1o.t1) ? w_lim : w_s1o.t1;

        w_s2.x0   = w_s1o.x0;
        w_s2.vneg = w_s1o.vneg;
        w_s2.vm   = d1_div[N1];
        w_s2.zero = w_s1o.zero || (w_t1e == '0) || (w_s1o.t >= w_t1e);

        d2_v[0]   = d1_v[N1];
        d2_rem[0] = w_s2.zero ? '0 : w_s1o.t;
        d2_sh[0]  = '0;
        d2_div[0] = w_t1e;
        d2_sd[0]  = w_s2;
    end

    assign d1_r[N1] = d2_r[0];

    for (genvar k = 0; k < N2; k++) begin : g_norm
        qode_div_cell #(.RW(32), .QW(N2), .SW(S2W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d2_v[k]),
            .o_ready (d2_r[k]),
            .i_rem   (d2_rem[k]),
            .i_sh    (d2_sh[k]),
            .i_div   (d2_div[k]),
            .i_side  (d2_sd[k]),
            .o_valid (d2_v[k+1]),
            .i_ready (d2_r[k+1]),
            .o_rem   (d2_rem[k+1]),
            .o_sh    (d2_sh[k+1]),
            .o_div   (d2_div[k+1]),
            .o_side  (d2_sd[k+1])
        );
    end

    assign w_s2o = qode_pkg::t_side2'(d2_sd[N2]);

    qode_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (d2_v[N2]),
        .o_ready      (d2_r[N2]),
        .i_u          (d2_sh[N2]),
        .i_t1         (d2_div[N2]),
        .i_side       (w_s2o),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_offset_now (o_offset_now)
    );

endmodule

// ===== dv/quintic_offset_decay_eval_test.sv =====
// self-checking testbench for the quintic offset decay evaluator
// depends on quintic_offset_decay_eval and qode_pkg; directed table then random beats
module quintic_offset_decay_eval_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = qode_pkg::FRAC_BITS;
    localparam int NRAND = 1230;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [30:0] SAT = qode_pkg::OUT_MAX;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_offset_start;
    logic [31:0] i_velocity_start;
    logic [31:0] i_blend_duration;
    logic [31:0] i_elapsed_time;
    logic        o_valid;
    logic        i_ready;
    logic [30:0] o_offset_now;

    quintic_offset_decay_eval u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_offset_start  (i_offset_start),
        .i_velocity_start(i_velocity_start),
        .i_blend_duration(i_blend_duration),
        .i_elapsed_time  (i_elapsed_time),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_offset_now    (o_offset_now)
    );

    typedef struct {
        logic [31:0] x0;
        logic [31:0] v0;
        logic [31:0] t1;
        logic [31:0] t;
        bit          known;
        logic [30:0] res;
    } t_row;

    logic [30:0] offset_queue[$];
    int          errors;
    int          n_sent;
    int          n_got;
    int          n_zero;
    int          n_sat;
    longint      cycles;
    bit          send_done;
    bit          long_hold;

    function automatic logic [63:0] umul30(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return p[93:30];
    endfunction

    function automatic logic [30:0] decayed_offset(logic [31:0] x0r, logic [31:0] v0r,
                                                   logic [31:0] t1r, logic [31:0] tr);
        logic [63:0] x0, vm, t1, t, lim, u, w, w3, h, g, a, b, one;
        logic [127:0] p;
        bit neg;
        one = 64'd1 << 30;
        if (t1r == 0 || $signed(x0r) <= 0) return '0;
        x0 = {32'd0, x0r};
        neg = v0r[31];
        vm = neg ? {32'd0, -v0r} : {32'd0, v0r};
        t1 = {32'd0, t1r};
        t = {32'd0, tr};
        if (neg) begin
            lim = ((x0 * 5) << FB) / vm;
            if (lim < t1) t1 = lim;
            if (t1 == 0) return '0;
        end
        if (t >= t1) return '0;
        u = (t << 30) / t1;
        w = one - u;
        w3 = umul30(umul30(w, w), w);
        h = umul30(w3, one + 3 * u + 6 * umul30(u, u));
        g = umul30(umul30(u, w3), one + 3 * u);
        a = (x0 * h) >> 30;
        p = vm * g;
        p = (p >> 30) * t1;
        b = p >> FB;
        if (neg) begin
            if (b >= a) return '0;
            a = a - b;
        end else begin
            a = a + b;
        end
        return (a > {33'd0, SAT}) ? SAT : a[30:0];
    endfunction

    t_row stim_table[] = '{
        '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 31'd0},
        '{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1, 31'd0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1, 31'd0},
        '{32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1, 31'h0001_0000},
        '{32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1, 31'd0},
        '{32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1, 31'd0},
        '{32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1, 31'h7FFF_FFFF},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0, 31'd0},
        '{32'h0000_0001, 32'h8000_0000, 32'h0001_0000, 32'h0000_0000, 1, 31'd0},
        '{32'h0001_0000, 32'hFFFF_0000, 32'h0100_0000, 32'h0002_0000, 0, 31'd0},
        '{32'h0001_0000, 32'hFFFF_0000, 32'h0100_0000, 32'h0005_0000, 1, 31'd0},
        '{32'h0001_0000, 32'h8000_0000, 32'h0100_0000, 32'h0000_0100, 0, 31'd0},
        '{32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h4000_0000, 0, 31'd0},
        '{32'h0001_0000, 32'h0004_0000, 32'h0002_0000, 32'h0000_8000, 0, 31'd0},
        '{32'h0003_0000, 32'hFFF0_0000, 32'h0001_0000, 32'h0000_0800, 0, 31'd0},
        '{32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_FFFF, 0, 31'd0},
        '{32'h0001_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1, 31'h0001_0000},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1, 31'd0}
    };

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return $urandom_range(0, 32'h0010_0000);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_beat(logic [31:0] x0, logic [31:0] v0, logic [31:0] t1,
                             logic [31:0] t);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 1)) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_offset_start <= x0;
        i_velocity_start <= v0;
        i_blend_duration <= t1;
        i_elapsed_time <= t;
        offset_queue.push_back(decayed_offset(x0, v0, t1, t));
        n_sent++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        logic [30:0] pred;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_offset_start = '0;
        i_velocity_start = '0;
        i_blend_duration = '0;
        i_elapsed_time = '0;
        errors = 0;
        n_sent = 0;
        send_done = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (stim_table[k]) begin
            pred = decayed_offset(stim_table[k].x0, stim_table[k].v0, stim_table[k].t1,
                                  stim_table[k].t);
            if (stim_table[k].known && pred != stim_table[k].res) begin
                $display("%0t table row %0d expected %h actual %h", $time, k,
                         stim_table[k].res, pred);
                errors++;
            end
            send_beat(stim_table[k].x0, stim_table[k].v0, stim_table[k].t1,
                      stim_table[k].t);
        end
        for (int n = 0; n < NRAND; n++) begin
            logic [31:0] x0, v0, t1, t;
            x0 = rand_word();
            v0 = rand_word();
            t1 = rand_word();
            t = rand_word();
            if ($urandom_range(0, 3) != 0) begin
                x0 = $urandom_range(1, 32'h7FFF_FFFF);
                t1 = $urandom_range(1, 32'hFFFF_FFFF);
                t = $urandom_range(0, t1 - 1);
                if ($urandom_range(0, 1)) v0 = $signed($urandom()) >>> $urandom_range(0, 16);
            end
            send_beat(x0, v0, t1, t);
        end
        i_valid <= 1'b0;
        send_done = 1;
    end

    initial begin
        int gap;
        i_ready = 1'b0;
        long_hold = 0;
        n_got = 0;
        n_zero = 0;
        n_sat = 0;
        @(posedge i_rst_n);
        forever begin
            if (!long_hold && n_got == 40) begin
                long_hold = 1;
                i_ready <= 1'b0;
                repeat (500) @(posedge i_clk);
            end
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (offset_queue.size() == 0) begin
                $display("%0t unexpected beat, actual %h", $time, o_offset_now);
                errors++;
            end else begin
                logic [30:0] want;
                want = offset_queue.pop_front();
                if (want != o_offset_now) begin
                    $display("%0t offset_now expected %h actual %h", $time, want, o_offset_now);
                    errors++;
                end
            end
            if (o_offset_now == 0) n_zero++;
            if (o_offset_now == SAT) n_sat++;
            n_got++;
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Verification failed");
                $finish;
            end
            if (send_done && offset_queue.size() == 0) begin
                repeat (150) @(posedge i_clk);
                $display("%0d beats sent, %0d results (%0d zero, %0d saturated)",
                         n_sent, n_got, n_zero, n_sat);
                if (errors == 0 && offset_queue.size() == 0) begin
                    $display("Verification passed");
                end else begin
                    $display("Verification failed");
                end
                $finish;
            end
        end
    end
endmodule

// ===== sim.f =====
+incdir+src
src/qode_pkg.sv
src/qode_div_cell.sv
src/qode_poly.sv
src/quintic_offset_decay_eval.sv
dv/quintic_offset_decay_eval_test.sv
